@@ sv/flpte_pkg.sv @@
// shared types, constants and codes of the four-level page table engine
package flpte_pkg;

    localparam int TABLE_FRAMES_DEF = 16;
    localparam int ENTRY_W          = 64;
    localparam int IDX_W            = 9;
    localparam int ENTRIES          = 512;
    localparam int PAGE_SHIFT       = 12;
    localparam int PA_W             = 52;
    localparam int VA_W             = 48;
    localparam int PFN_W            = PA_W - PAGE_SHIFT;
    localparam int VPN_W            = VA_W - PAGE_SHIFT;
    localparam int FLAGS_W          = 5;
    localparam int LEVELS           = 4;

    localparam logic [1:0] LAST_LEVEL = 2'(LEVELS - 1);

    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_MISALIGNED = 3'd1;
    localparam logic [2:0] STS_NOT_MAPPED = 3'd2;
    localparam logic [2:0] STS_NO_SPACE   = 3'd3;
    localparam logic [2:0] STS_BAD_PTR    = 3'd4;

    // present, writable and user bits of a table entry
    localparam logic [ENTRY_W-1:0] ENT_TABLE_BITS = 64'h7;

    typedef struct packed {
        logic [1:0]         command;
        logic [VA_W-1:0]    virt_addr;
        logic [PA_W-1:0]    phys_addr_in;
        logic [FLAGS_W-1:0] page_flags;
    } in_t;

    typedef struct packed {
        logic [2:0]      status;
        logic [PA_W-1:0] phys_addr_out;
    } out_t;

endpackage

@@ sv/flpte_ram.sv @@
// generic single-port synchronous ram with registered read
module flpte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ sv/flpte_walker.sv @@
// table walk sequencer: clearing pass, level walk, frame allocation and leaf update
module flpte_walker
    import flpte_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PFN_W-1:0]      base_pfn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  res_valid,
    input  logic                  res_ready,
    output out_t                  res_data,
    output logic                  mem_we,
    output logic [$clog2(TABLE_FRAMES)+IDX_W-1:0] mem_addr,
    output logic [ENTRY_W-1:0]    mem_wdata,
    input  logic [ENTRY_W-1:0]    mem_rdata
);

    localparam int FRAME_W = $clog2(TABLE_FRAMES);
    localparam int ADDR_W  = FRAME_W + IDX_W;
    localparam int DEPTH   = TABLE_FRAMES * ENTRIES;
    localparam int NFREE_W = $clog2(TABLE_FRAMES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FILL,
        S_ALLOC,
        S_RESP
    } state_t;

    state_t               state_reg;
    logic [1:0]           level_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [1:0]           cmd_reg;
    logic [VPN_W-1:0]     va_reg;
    logic [PFN_W-1:0]     pa_reg;
    logic [FLAGS_W-1:0]   flags_reg;
    logic [ADDR_W-1:0]    ent_addr_reg;
    logic [ADDR_W-1:0]    clr_reg;
    logic [NFREE_W-1:0]   next_free_reg;
    logic                 dirty_vld_reg;
    logic [FRAME_W-1:0]   dirty_max_reg;
    out_t                 res_reg;

    logic [5:0]           vshift;
    logic [IDX_W-1:0]     idx;
    logic [ADDR_W-1:0]    read_addr;
    logic [PFN_W-1:0]     ent_pfn;
    logic                 present;
    logic [PFN_W-1:0]     ptr_off;
    logic                 bad_ptr;
    logic [FRAME_W-1:0]   nf_frame;
    logic                 space_full;
    logic                 need_clear;
    logic [ENTRY_W-1:0]   alloc_entry;
    logic [ENTRY_W-1:0]   leaf_entry;
    logic                 is_map;
    logic                 is_unmap;
    logic                 fill_last;
    logic                 clear_last;
    logic                 leaf_write;
    logic                 misaligned;
    logic                 dirty_hit;

    always_comb begin
        vshift      = 6'(IDX_W) * (6'(LAST_LEVEL) - 6'(level_reg));
        idx         = IDX_W'(va_reg >> vshift);
        read_addr   = {frame_reg, idx};
        ent_pfn     = mem_rdata[PA_W-1:PAGE_SHIFT];
        present     = mem_rdata[0];
        ptr_off     = ent_pfn - base_pfn;
        bad_ptr     = ptr_off >= PFN_W'(TABLE_FRAMES);
        nf_frame    = next_free_reg[FRAME_W-1:0];
        space_full  = next_free_reg >= NFREE_W'(TABLE_FRAMES);
        need_clear  = dirty_vld_reg && (dirty_max_reg >= nf_frame);
        alloc_entry = ENTRY_W'({base_pfn + PFN_W'(next_free_reg), PAGE_SHIFT'(0)})
                    | ENT_TABLE_BITS;
        leaf_entry  = {flags_reg[4], 11'b0, pa_reg, 7'b0, flags_reg[3:0], 1'b1};
        is_map      = cmd_reg == CMD_MAP;
        is_unmap    = cmd_reg == CMD_UNMAP;
        fill_last   = clr_reg[IDX_W-1:0] == {IDX_W{1'b1}};
        clear_last  = clr_reg == ADDR_W'(DEPTH - 1);
        leaf_write  = (state_reg == S_EVAL) && (level_reg == LAST_LEVEL)
                    && ((is_map && !present) || (is_unmap && present));
        misaligned  = ((in_data.command == CMD_MAP)
                       && ((in_data.virt_addr[PAGE_SHIFT-1:0] != '0)
                           || (in_data.phys_addr_in[PAGE_SHIFT-1:0] != '0)))
                    || ((in_data.command == CMD_UNMAP)
                        && (in_data.virt_addr[PAGE_SHIFT-1:0] != '0));
        dirty_hit   = !dirty_vld_reg || (frame_reg > dirty_max_reg);
    end

    always_comb begin
        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            S_READ: begin
                mem_we    = 1'b0;
                mem_addr  = read_addr;
                mem_wdata = '0;
            end
            S_EVAL: begin
                mem_we    = leaf_write;
                mem_addr  = ent_addr_reg;
                mem_wdata = is_map ? leaf_entry : '0;
            end
            S_FILL: begin
                mem_we    = 1'b1;
                mem_addr  = {nf_frame, clr_reg[IDX_W-1:0]};
                mem_wdata = '0;
            end
            S_ALLOC: begin
                mem_we    = 1'b1;
                mem_addr  = ent_addr_reg;
                mem_wdata = alloc_entry;
            end
            default: begin
                mem_we    = 1'b0;
                mem_addr  = ent_addr_reg;
                mem_wdata = '0;
            end
        endcase
    end

    assign in_ready  = state_reg == S_IDLE;
    assign res_valid = state_reg == S_RESP;
    assign res_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            next_free_reg <= NFREE_W'(1);
            dirty_vld_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clear_last) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        cmd_reg   <= in_data.command;
                        va_reg    <= in_data.virt_addr[VA_W-1:PAGE_SHIFT];
                        pa_reg    <= in_data.phys_addr_in[PA_W-1:PAGE_SHIFT];
                        flags_reg <= in_data.page_flags;
                        level_reg <= '0;
                        frame_reg <= '0;
                        if (misaligned) begin
                            res_reg.status        <= STS_MISALIGNED;
                            res_reg.phys_addr_out <= '0;
                            state_reg             <= S_RESP;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    ent_addr_reg <= read_addr;
                    state_reg    <= S_EVAL;
                end
                S_EVAL: begin
                    if (level_reg != LAST_LEVEL) begin
                        if (present) begin
                            if (bad_ptr) begin
                                res_reg.status        <= STS_BAD_PTR;
                                res_reg.phys_addr_out <= '0;
                                state_reg             <= S_RESP;
                            end else begin
                                frame_reg <= ptr_off[FRAME_W-1:0];
                                level_reg <= level_reg + 1'b1;
                                state_reg <= S_READ;
                            end
                        end else if (!is_map) begin
                            res_reg.status        <= STS_NOT_MAPPED;
                            res_reg.phys_addr_out <= '0;
                            state_reg             <= S_RESP;
                        end else if (space_full) begin
                            res_reg.status        <= STS_NO_SPACE;
                            res_reg.phys_addr_out <= '0;
                            state_reg             <= S_RESP;
                        end else if (need_clear) begin
                            clr_reg   <= '0;
                            state_reg <= S_FILL;
                        end else begin
                            state_reg <= S_ALLOC;
                        end
                    end else begin
                        if (present) begin
                            res_reg.status        <= STS_OK;
                            res_reg.phys_addr_out <= {ent_pfn, PAGE_SHIFT'(0)};
                        end else if (is_map) begin
                            res_reg.status        <= STS_OK;
                            res_reg.phys_addr_out <= {pa_reg, PAGE_SHIFT'(0)};
                        end else begin
                            res_reg.status        <= STS_NOT_MAPPED;
                            res_reg.phys_addr_out <= '0;
                        end
                        if (leaf_write && dirty_hit) begin
                            dirty_vld_reg <= 1'b1;
                            dirty_max_reg <= frame_reg;
                        end
                        state_reg <= S_RESP;
                    end
                end
                S_FILL: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (fill_last) begin
                        state_reg <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    next_free_reg <= next_free_reg + 1'b1;
                    frame_reg     <= nf_frame;
                    level_reg     <= level_reg + 1'b1;
                    if (dirty_hit) begin
                        dirty_vld_reg <= 1'b1;
                        dirty_max_reg <= frame_reg;
                    end
                    state_reg <= S_READ;
                end
                S_RESP: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/four_level_page_table_engine_top.sv @@
// top level of the four-level page table engine
//
// s_ channel: one transfer carries a map, unmap or translate command; m_ channel:
// one transfer carries the status and leaf physical address for each command.
// The user writes table_base through cfg_we / cfg_wdata while the engine is
// idle; the block itself does not enforce this. All table entries sit in one
// single-port ram of TABLE_FRAMES*512 words with a registered read; the
// sequencer passes through a read state and an evaluate state on each of the
// four levels, and the engine takes a new command only after the walker has
// handed its result to the output register. A misaligned command skips the
// walk and frees the engine when its result is taken into the output register.
// Each table created by map adds an allocation write; when a frame at or above
// the one being allocated has been written, the new frame is first cleared.
// After reset the whole table ram, TABLE_FRAMES*512 words (8192 by default), is
// swept to zero with s_ready low; the root frame and allocator restart.
// The result sits in an output register: while the receiver stalls one result
// waits there, the engine may finish one more command and then holds it with
// s_ready low until the register drains.
module four_level_page_table_engine_top
    import flpte_pkg::*;
#(
    parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [PA_W-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_t             s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output out_t            m_data
);

    localparam int ADDR_W = $clog2(TABLE_FRAMES) + IDX_W;

    logic [PFN_W-1:0]   base_pfn_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic               res_valid;
    logic               res_ready;
    out_t               res_data;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_pfn_reg <= '0;
        end else if (cfg_we) begin
            base_pfn_reg <= cfg_wdata[PA_W-1:PAGE_SHIFT];
        end
    end

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= res_data;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    flpte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_FRAMES * ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    flpte_walker #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .base_pfn  (base_pfn_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    a_no_accept_with_result: assert property (
        @(posedge aclk) disable iff (!aresetn) res_valid |-> !s_ready
    ) else $error("input accepted while a result is pending");

    a_one_command_at_a_time: assert property (
        @(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |=> !s_ready
    ) else $error("second command taken during a walk");

    a_zero_addr_on_error: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == STS_OK || m_data.phys_addr_out == '0)
    ) else $error("nonzero address with error status");

    a_page_aligned_out: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.phys_addr_out[PAGE_SHIFT-1:0] == '0)
    ) else $error("result address not page aligned");

endmodule
